FILE: rtl/core/lpf2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpf2d_pkg;

  localparam int OP_W     = 34;
  localparam int PROD_W   = 2 * OP_W;
  localparam int CORDIC_W = 36;
  localparam int ANG_W    = 18;
  localparam int SUM_W    = 35;
  localparam int SCL_W    = 20;
  localparam int NUM_W    = 42;
  localparam int GAIN_W   = 30;
  localparam int QUO_W    = 30;
  localparam int GAIN_FRAC = 24;
  localparam int RNG_FRAC  = 16;
  localparam int TRIG_FRAC = 30;
  localparam int REM_W    = NUM_W + GAIN_FRAC;
  localparam int DSH_W    = NUM_W + QUO_W;

  localparam logic [3:0] CORDIC_LAST = 4'd13;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [ANG_W-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 36'sd652032875;
  localparam logic [SUM_W-1:0] SCALE_LIMIT = 35'd262144;
  localparam logic [QUO_W-1:0] GAIN_LIMIT  = 30'd268435456;
  localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] CFG_ALONG    = 3'd0;
  localparam logic [2:0] CFG_ACROSS   = 3'd1;
  localparam logic [2:0] CFG_POS_X    = 3'd2;
  localparam logic [2:0] CFG_POS_Y    = 3'd3;
  localparam logic [2:0] CFG_VAR_X    = 3'd4;
  localparam logic [2:0] CFG_VAR_Y    = 3'd5;
  localparam logic [2:0] CFG_COV_XY   = 3'd6;

  function automatic logic [12:0] atan_q13(input logic [3:0] idx);
    logic [12:0] v;
    case (idx)
      4'd0:  v = 13'd6434;
      4'd1:  v = 13'd3798;
      4'd2:  v = 13'd2007;
      4'd3:  v = 13'd1019;
      4'd4:  v = 13'd511;
      4'd5:  v = 13'd256;
      4'd6:  v = 13'd128;
      4'd7:  v = 13'd64;
      4'd8:  v = 13'd32;
      4'd9:  v = 13'd16;
      4'd10: v = 13'd8;
      4'd11: v = 13'd4;
      4'd12: v = 13'd2;
      4'd13: v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] sat_u31(input logic signed [PROD_W-1:0] v);
    logic [30:0] r;
    if (v[PROD_W-1:31] != '0) r = U31_MAX;
    else r = v[30:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) r = v[31:0];
    else if (v[PROD_W-1]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] mag35(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/landmark_position_fusion_2d_core.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  meas, range, vehicle pose, heading
// result    out        out_valid_o / out_stall_i fused estimate, covariance, singular flag
// config    in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// The four 30-step gain divisions and the 31 products through the single 34x34
// multiplier take up most of the time of one request.
// A singular covariance sum ends the request before the gain divisions.
// Reset loads the estimate and coefficients with their default values.
// The block takes no request until the result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module landmark_position_fusion_2d_core (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire signed [31:0]  meas_x_i,
  input  wire signed [31:0]  meas_y_i,
  input  wire        [30:0]  range_to_target_i,
  input  wire signed [31:0]  vehicle_x_i,
  input  wire signed [31:0]  vehicle_y_i,
  input  wire signed [15:0]  vehicle_heading_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] fused_x_o,
  output logic signed [31:0] fused_y_o,
  output logic signed [31:0] fused_var_x_o,
  output logic signed [31:0] fused_var_y_o,
  output logic signed [31:0] fused_cov_xy_o,
  output logic               singular_flag_o,
  input  wire                cfg_we_i,
  input  wire        [2:0]   cfg_idx_i,
  input  wire        [31:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_VPRE, S_VEC, S_FOLD, S_ROT, S_NSUM, S_NMAX, S_NK,
    S_NSCALE, S_DIVLD, S_DIVIT, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    MS_RR, MS_A, MS_B, MS_CC, MS_SS, MS_SC, MS_M00A, MS_M00B, MS_M11A, MS_M11B,
    MS_M01, MS_DET0, MS_DET1, MS_N00A, MS_N00B, MS_N01A, MS_N01B, MS_N10A,
    MS_N10B, MS_N11A, MS_N11B, MS_X0, MS_X1, MS_Y0, MS_Y1, MS_VX0, MS_VX1,
    MS_CV0, MS_CV1, MS_VY0, MS_VY1
  } step_e;

  state_e state_q;
  step_e  step_q;
  logic   ph_q;
  logic [3:0] i_q;
  logic [4:0] k_q;
  logic [4:0] cnt_q;
  logic [1:0] div_idx_q;
  logic       sing_q;

  logic [30:0] along_q, across_q;
  logic signed [31:0] est_x_q, est_y_q, est_var_x_q, est_var_y_q, est_cov_xy_q;

  logic [30:0] r_q, rr_q, a_q, b_q;
  logic signed [15:0] hd_q;
  logic signed [32:0] dx_q, dy_q, ex_q, ey_q;
  logic signed [CORDIC_W_L-1:0] x_q, y_q;
  logic signed [lpf2d_pkg::ANG_W-1:0] z_q;
  logic signed [31:0] cc_q, ss_q, sc_q, m01_q;
  logic signed [32:0] m00_q, m11_q;
  logic signed [lpf2d_pkg::SUM_W-1:0] sa_q, sb_q, sd_q;
  logic [lpf2d_pkg::SUM_W-1:0] msh_q;
  logic signed [lpf2d_pkg::SCL_W-1:0] as_q, bs_q, ds_q, ps_q, qs_q, vs_q;
  logic signed [lpf2d_pkg::NUM_W-1:0] det_q;
  logic signed [lpf2d_pkg::NUM_W-1:0] num_q [4];
  logic signed [lpf2d_pkg::GAIN_W-1:0] g_q [4];
  logic [lpf2d_pkg::REM_W-1:0] rem_q;
  logic [lpf2d_pkg::DSH_W-1:0] dsh_q;
  logic [lpf2d_pkg::QUO_W-1:0] q_q;
  logic ovf_q, neg_q;
  logic signed [lpf2d_pkg::PROD_W-1:0] prod_q, acc_q;

  localparam int CORDIC_W_L = lpf2d_pkg::CORDIC_W;

  logic signed [lpf2d_pkg::OP_W-1:0] opa, opb;
  logic mac_first, mac_sub;
  logic signed [lpf2d_pkg::PROD_W-1:0] mac_base, mac_sum;
  logic signed [31:0] amb;
  logic signed [CORDIC_W_L-1:0] xsh, ysh;
  logic signed [lpf2d_pkg::ANG_W-1:0] atn, vec_z;
  logic fold_hi, fold_lo, zero_dir, req_acc;
  logic [lpf2d_pkg::SUM_W-1:0] mg_a, mg_b, mg_d, mg_p, mg_q, mg_s, mx1, mx2, mx3, mmax;
  logic signed [lpf2d_pkg::NUM_W-1:0] div_num;
  logic [lpf2d_pkg::NUM_W-1:0] nmag, dmag;
  logic div_ge;
  logic [lpf2d_pkg::QUO_W-1:0] q_next, gmag;
  logic signed [lpf2d_pkg::GAIN_W-1:0] g_val;

  assign req_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign fused_x_o      = est_x_q;
  assign fused_y_o      = est_y_q;
  assign fused_var_x_o  = est_var_x_q;
  assign fused_var_y_o  = est_var_y_q;
  assign fused_cov_xy_o = est_cov_xy_q;
  assign singular_flag_o = sing_q;

  assign amb = $signed({1'b0, a_q}) - $signed({1'b0, b_q});

  always_comb begin
    opa = '0;
    opb = '0;
    mac_first = 1'b1;
    mac_sub = 1'b0;
    case (step_q)
      MS_RR:   begin opa = lpf2d_pkg::OP_W'(r_q);  opb = lpf2d_pkg::OP_W'(r_q); end
      MS_A:    begin opa = lpf2d_pkg::OP_W'(rr_q); opb = lpf2d_pkg::OP_W'(along_q); end
      MS_B:    begin opa = lpf2d_pkg::OP_W'(r_q);  opb = lpf2d_pkg::OP_W'(across_q); end
      MS_CC:   begin opa = x_q[lpf2d_pkg::OP_W-1:0]; opb = x_q[lpf2d_pkg::OP_W-1:0]; end
      MS_SS:   begin opa = y_q[lpf2d_pkg::OP_W-1:0]; opb = y_q[lpf2d_pkg::OP_W-1:0]; end
      MS_SC:   begin opa = y_q[lpf2d_pkg::OP_W-1:0]; opb = x_q[lpf2d_pkg::OP_W-1:0]; end
      MS_M00A: begin opa = lpf2d_pkg::OP_W'(a_q); opb = lpf2d_pkg::OP_W'(cc_q); end
      MS_M00B: begin
        opa = lpf2d_pkg::OP_W'(b_q); opb = lpf2d_pkg::OP_W'(ss_q); mac_first = 1'b0;
      end
      MS_M11A: begin opa = lpf2d_pkg::OP_W'(a_q); opb = lpf2d_pkg::OP_W'(ss_q); end
      MS_M11B: begin
        opa = lpf2d_pkg::OP_W'(b_q); opb = lpf2d_pkg::OP_W'(cc_q); mac_first = 1'b0;
      end
      MS_M01:  begin opa = lpf2d_pkg::OP_W'(amb); opb = lpf2d_pkg::OP_W'(sc_q); end
      MS_DET0: begin opa = lpf2d_pkg::OP_W'(as_q); opb = lpf2d_pkg::OP_W'(ds_q); end
      MS_DET1: begin
        opa = lpf2d_pkg::OP_W'(bs_q); opb = lpf2d_pkg::OP_W'(bs_q);
        mac_first = 1'b0; mac_sub = 1'b1;
      end
      MS_N00A: begin opa = lpf2d_pkg::OP_W'(ps_q); opb = lpf2d_pkg::OP_W'(ds_q); end
      MS_N00B: begin
        opa = lpf2d_pkg::OP_W'(qs_q); opb = lpf2d_pkg::OP_W'(bs_q);
        mac_first = 1'b0; mac_sub = 1'b1;
      end
      MS_N01A: begin opa = lpf2d_pkg::OP_W'(qs_q); opb = lpf2d_pkg::OP_W'(as_q); end
      MS_N01B: begin
        opa = lpf2d_pkg::OP_W'(ps_q); opb = lpf2d_pkg::OP_W'(bs_q);
        mac_first = 1'b0; mac_sub = 1'b1;
      end
      MS_N10A: begin opa = lpf2d_pkg::OP_W'(qs_q); opb = lpf2d_pkg::OP_W'(ds_q); end
      MS_N10B: begin
        opa = lpf2d_pkg::OP_W'(vs_q); opb = lpf2d_pkg::OP_W'(bs_q);
        mac_first = 1'b0; mac_sub = 1'b1;
      end
      MS_N11A: begin opa = lpf2d_pkg::OP_W'(vs_q); opb = lpf2d_pkg::OP_W'(as_q); end
      MS_N11B: begin
        opa = lpf2d_pkg::OP_W'(qs_q); opb = lpf2d_pkg::OP_W'(bs_q);
        mac_first = 1'b0; mac_sub = 1'b1;
      end
      MS_X0:   begin opa = lpf2d_pkg::OP_W'(g_q[0]); opb = lpf2d_pkg::OP_W'(ex_q); end
      MS_X1:   begin
        opa = lpf2d_pkg::OP_W'(g_q[1]); opb = lpf2d_pkg::OP_W'(ey_q); mac_first = 1'b0;
      end
      MS_Y0:   begin opa = lpf2d_pkg::OP_W'(g_q[2]); opb = lpf2d_pkg::OP_W'(ex_q); end
      MS_Y1:   begin
        opa = lpf2d_pkg::OP_W'(g_q[3]); opb = lpf2d_pkg::OP_W'(ey_q); mac_first = 1'b0;
      end
      MS_VX0:  begin opa = lpf2d_pkg::OP_W'(g_q[0]); opb = lpf2d_pkg::OP_W'(m00_q); end
      MS_VX1:  begin
        opa = lpf2d_pkg::OP_W'(g_q[1]); opb = lpf2d_pkg::OP_W'(m01_q); mac_first = 1'b0;
      end
      MS_CV0:  begin opa = lpf2d_pkg::OP_W'(g_q[0]); opb = lpf2d_pkg::OP_W'(m01_q); end
      MS_CV1:  begin
        opa = lpf2d_pkg::OP_W'(g_q[1]); opb = lpf2d_pkg::OP_W'(m11_q); mac_first = 1'b0;
      end
      MS_VY0:  begin opa = lpf2d_pkg::OP_W'(g_q[2]); opb = lpf2d_pkg::OP_W'(m01_q); end
      MS_VY1:  begin
        opa = lpf2d_pkg::OP_W'(g_q[3]); opb = lpf2d_pkg::OP_W'(m11_q); mac_first = 1'b0;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    mac_base = mac_first ? '0 : acc_q;
    mac_sum  = mac_sub ? (mac_base - prod_q) : (mac_base + prod_q);
  end

  always_comb begin
    xsh = x_q >>> i_q;
    ysh = y_q >>> i_q;
    atn = $signed(lpf2d_pkg::ANG_W'(lpf2d_pkg::atan_q13(i_q)));
    vec_z = (y_q > 0) ? (z_q + atn) : (z_q - atn);
    fold_hi = (z_q > lpf2d_pkg::HALF_PI_Q13);
    fold_lo = (z_q < -lpf2d_pkg::HALF_PI_Q13);
    zero_dir = (dx_q == '0) && (dy_q == '0);
  end

  always_comb begin
    mg_a = lpf2d_pkg::mag35(sa_q);
    mg_b = lpf2d_pkg::mag35(sb_q);
    mg_d = lpf2d_pkg::mag35(sd_q);
    mg_p = lpf2d_pkg::mag35(lpf2d_pkg::SUM_W'(est_var_x_q));
    mg_q = lpf2d_pkg::mag35(lpf2d_pkg::SUM_W'(est_cov_xy_q));
    mg_s = lpf2d_pkg::mag35(lpf2d_pkg::SUM_W'(est_var_y_q));
    mx1 = (mg_a > mg_b) ? mg_a : mg_b;
    mx2 = (mg_d > mg_p) ? mg_d : mg_p;
    mx3 = (mg_q > mg_s) ? mg_q : mg_s;
    mmax = (mx1 > mx2) ? mx1 : mx2;
    mmax = (mmax > mx3) ? mmax : mx3;
  end

  always_comb begin
    div_num = num_q[div_idx_q];
    nmag = div_num[lpf2d_pkg::NUM_W-1] ? lpf2d_pkg::NUM_W'(-div_num)
                                       : lpf2d_pkg::NUM_W'(div_num);
    dmag = det_q[lpf2d_pkg::NUM_W-1] ? lpf2d_pkg::NUM_W'(-det_q)
                                     : lpf2d_pkg::NUM_W'(det_q);
    div_ge = (lpf2d_pkg::DSH_W'(rem_q) >= dsh_q);
    q_next = {q_q[lpf2d_pkg::QUO_W-2:0], div_ge};
    gmag = (ovf_q || (q_next > lpf2d_pkg::GAIN_LIMIT)) ? lpf2d_pkg::GAIN_LIMIT : q_next;
    g_val = neg_q ? -$signed(gmag) : $signed(gmag);
  end

  // control, configuration and kept estimate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= MS_RR;
      ph_q <= 1'b0;
      i_q <= '0;
      k_q <= '0;
      cnt_q <= '0;
      div_idx_q <= '0;
      sing_q <= 1'b0;
      along_q <= 31'd65536;
      across_q <= 31'd65536;
      est_x_q <= '0;
      est_y_q <= '0;
      est_var_x_q <= 32'sd65536;
      est_var_y_q <= 32'sd65536;
      est_cov_xy_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lpf2d_pkg::CFG_ALONG:  along_q <= cfg_data_i[30:0];
          lpf2d_pkg::CFG_ACROSS: across_q <= cfg_data_i[30:0];
          lpf2d_pkg::CFG_POS_X:  est_x_q <= $signed(cfg_data_i);
          lpf2d_pkg::CFG_POS_Y:  est_y_q <= $signed(cfg_data_i);
          lpf2d_pkg::CFG_VAR_X:  est_var_x_q <= $signed({1'b0, cfg_data_i[30:0]});
          lpf2d_pkg::CFG_VAR_Y:  est_var_y_q <= $signed({1'b0, cfg_data_i[30:0]});
          lpf2d_pkg::CFG_COV_XY: est_cov_xy_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MAC;
            step_q <= MS_RR;
            ph_q <= 1'b0;
            sing_q <= 1'b0;
          end
        end
        S_MAC: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            step_q <= (step_q == MS_VY1) ? MS_RR : step_e'(step_q + 5'd1);
            case (step_q)
              MS_B:    state_q <= S_VPRE;
              MS_M01:  state_q <= S_NSUM;
              MS_DET1: begin
                if (mac_sum == '0) begin
                  sing_q <= 1'b1;
                  state_q <= S_DONE;
                end
              end
              MS_N11B: begin
                div_idx_q <= '0;
                state_q <= S_DIVLD;
              end
              MS_X1: est_x_q <= lpf2d_pkg::sat_s32(lpf2d_pkg::PROD_W'(est_x_q)
                                  + (mac_sum >>> lpf2d_pkg::GAIN_FRAC));
              MS_Y1: est_y_q <= lpf2d_pkg::sat_s32(lpf2d_pkg::PROD_W'(est_y_q)
                                  + (mac_sum >>> lpf2d_pkg::GAIN_FRAC));
              MS_VX1: est_var_x_q <= lpf2d_pkg::sat_s32(mac_sum >>> lpf2d_pkg::GAIN_FRAC);
              MS_CV1: est_cov_xy_q <= lpf2d_pkg::sat_s32(mac_sum >>> lpf2d_pkg::GAIN_FRAC);
              MS_VY1: begin
                est_var_y_q <= lpf2d_pkg::sat_s32(mac_sum >>> lpf2d_pkg::GAIN_FRAC);
                state_q <= S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_VPRE: begin
          i_q <= '0;
          state_q <= zero_dir ? S_FOLD : S_VEC;
        end
        S_VEC: begin
          i_q <= i_q + 4'd1;
          if (i_q == lpf2d_pkg::CORDIC_LAST) state_q <= S_FOLD;
        end
        S_FOLD: begin
          if (!fold_hi && !fold_lo) begin
            i_q <= '0;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          i_q <= i_q + 4'd1;
          if (i_q == lpf2d_pkg::CORDIC_LAST) begin
            ph_q <= 1'b0;
            state_q <= S_MAC;
          end
        end
        S_NSUM: state_q <= S_NMAX;
        S_NMAX: begin
          k_q <= '0;
          state_q <= S_NK;
        end
        S_NK: begin
          if (msh_q > lpf2d_pkg::SCALE_LIMIT) k_q <= k_q + 5'd1;
          else state_q <= S_NSCALE;
        end
        S_NSCALE: begin
          ph_q <= 1'b0;
          state_q <= S_MAC;
        end
        S_DIVLD: begin
          cnt_q <= 5'(lpf2d_pkg::QUO_W - 1);
          state_q <= S_DIVIT;
        end
        S_DIVIT: begin
          if (cnt_q == '0) begin
            if (div_idx_q == 2'd3) begin
              ph_q <= 1'b0;
              state_q <= S_MAC;
            end else begin
              div_idx_q <= div_idx_q + 2'd1;
              state_q <= S_DIVLD;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_DONE: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          r_q <= range_to_target_i;
          hd_q <= vehicle_heading_i;
          dx_q <= 33'(meas_x_i) - 33'(vehicle_x_i);
          dy_q <= 33'(meas_y_i) - 33'(vehicle_y_i);
          ex_q <= 33'(meas_x_i) - 33'(est_x_q);
          ey_q <= 33'(meas_y_i) - 33'(est_y_q);
        end
      end
      S_MAC: begin
        if (!ph_q) begin
          prod_q <= opa * opb;
        end else begin
          acc_q <= mac_sum;
          case (step_q)
            MS_RR:   rr_q <= lpf2d_pkg::sat_u31(mac_sum >>> lpf2d_pkg::RNG_FRAC);
            MS_A:    a_q <= lpf2d_pkg::sat_u31(mac_sum >>> lpf2d_pkg::RNG_FRAC);
            MS_B:    b_q <= lpf2d_pkg::sat_u31(mac_sum >>> lpf2d_pkg::RNG_FRAC);
            MS_CC:   cc_q <= 32'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_SS:   ss_q <= 32'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_SC:   sc_q <= 32'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_M00B: m00_q <= 33'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_M11B: m11_q <= 33'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_M01:  m01_q <= 32'(mac_sum >>> lpf2d_pkg::TRIG_FRAC);
            MS_DET1: det_q <= lpf2d_pkg::NUM_W'(mac_sum);
            MS_N00B: num_q[0] <= lpf2d_pkg::NUM_W'(mac_sum);
            MS_N01B: num_q[1] <= lpf2d_pkg::NUM_W'(mac_sum);
            MS_N10B: num_q[2] <= lpf2d_pkg::NUM_W'(mac_sum);
            MS_N11B: num_q[3] <= lpf2d_pkg::NUM_W'(mac_sum);
            default: ;
          endcase
        end
      end
      S_VPRE: begin
        if (zero_dir) begin
          z_q <= lpf2d_pkg::ANG_W'(hd_q);
        end else if (dx_q[32]) begin
          if (!dy_q[32]) begin
            x_q <= CORDIC_W_L'(dy_q);
            y_q <= -CORDIC_W_L'(dx_q);
            z_q <= lpf2d_pkg::HALF_PI_Q13;
          end else begin
            x_q <= -CORDIC_W_L'(dy_q);
            y_q <= CORDIC_W_L'(dx_q);
            z_q <= -lpf2d_pkg::HALF_PI_Q13;
          end
        end else begin
          x_q <= CORDIC_W_L'(dx_q);
          y_q <= CORDIC_W_L'(dy_q);
          z_q <= '0;
        end
      end
      S_VEC: begin
        if (y_q > 0) begin
          x_q <= x_q + ysh;
          y_q <= y_q - xsh;
        end else begin
          x_q <= x_q - ysh;
          y_q <= y_q + xsh;
        end
        z_q <= (i_q == lpf2d_pkg::CORDIC_LAST) ? (vec_z + lpf2d_pkg::ANG_W'(hd_q)) : vec_z;
      end
      S_FOLD: begin
        if (fold_hi) begin
          z_q <= z_q - lpf2d_pkg::PI_Q13;
        end else if (fold_lo) begin
          z_q <= z_q + lpf2d_pkg::PI_Q13;
        end else begin
          x_q <= lpf2d_pkg::CORDIC_K_Q30;
          y_q <= '0;
        end
      end
      S_ROT: begin
        if (z_q >= 0) begin
          x_q <= x_q - ysh;
          y_q <= y_q + xsh;
          z_q <= z_q - atn;
        end else begin
          x_q <= x_q + ysh;
          y_q <= y_q - xsh;
          z_q <= z_q + atn;
        end
      end
      S_NSUM: begin
        sa_q <= lpf2d_pkg::SUM_W'(m00_q) + lpf2d_pkg::SUM_W'(est_var_x_q);
        sb_q <= lpf2d_pkg::SUM_W'(m01_q) + lpf2d_pkg::SUM_W'(est_cov_xy_q);
        sd_q <= lpf2d_pkg::SUM_W'(m11_q) + lpf2d_pkg::SUM_W'(est_var_y_q);
      end
      S_NMAX: msh_q <= mmax;
      S_NK: begin
        if (msh_q > lpf2d_pkg::SCALE_LIMIT) msh_q <= msh_q >> 1;
      end
      S_NSCALE: begin
        as_q <= lpf2d_pkg::SCL_W'(sa_q >>> k_q);
        bs_q <= lpf2d_pkg::SCL_W'(sb_q >>> k_q);
        ds_q <= lpf2d_pkg::SCL_W'(sd_q >>> k_q);
        ps_q <= lpf2d_pkg::SCL_W'(lpf2d_pkg::SUM_W'(est_var_x_q) >>> k_q);
        qs_q <= lpf2d_pkg::SCL_W'(lpf2d_pkg::SUM_W'(est_cov_xy_q) >>> k_q);
        vs_q <= lpf2d_pkg::SCL_W'(lpf2d_pkg::SUM_W'(est_var_y_q) >>> k_q);
      end
      S_DIVLD: begin
        rem_q <= {nmag, {lpf2d_pkg::GAIN_FRAC{1'b0}}};
        dsh_q <= lpf2d_pkg::DSH_W'(dmag) << (lpf2d_pkg::QUO_W - 1);
        ovf_q <= (lpf2d_pkg::DSH_W'({nmag, {lpf2d_pkg::GAIN_FRAC{1'b0}}})
                  >= (lpf2d_pkg::DSH_W'(dmag) << lpf2d_pkg::QUO_W));
        neg_q <= div_num[lpf2d_pkg::NUM_W-1] ^ det_q[lpf2d_pkg::NUM_W-1];
        q_q <= '0;
      end
      S_DIVIT: begin
        if (div_ge) rem_q <= rem_q - lpf2d_pkg::REM_W'(dsh_q);
        dsh_q <= dsh_q >> 1;
        q_q <= q_next;
        if (cnt_q == '0) g_q[div_idx_q] <= g_val;
      end
      default: ;
    endcase
  end

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> in_stall_o)
    else $error("request accepted but block not busy next cycle");

  a_no_req_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request channel open while result pending");

  a_scale_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 5'd17)
    else $error("normalization shift out of range");

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_MAC) |-> !ph_q)
    else $error("multiplier phase set outside product sequence");

endmodule
`default_nettype wire

FILE: dv/lpf2d_checker.sv
`timescale 1ns / 1ps
module lpf2d_checker
  import lpf2d_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire signed [31:0] meas_x_i,
  input  wire signed [31:0] meas_y_i,
  input  wire        [30:0] range_to_target_i,
  input  wire signed [31:0] vehicle_x_i,
  input  wire signed [31:0] vehicle_y_i,
  input  wire signed [15:0] vehicle_heading_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire signed [31:0] fused_x_i,
  input  wire signed [31:0] fused_y_i,
  input  wire signed [31:0] fused_var_x_i,
  input  wire signed [31:0] fused_var_y_i,
  input  wire signed [31:0] fused_cov_xy_i,
  input  wire               singular_flag_i,
  input  wire               cfg_we_i,
  input  wire        [2:0]  cfg_idx_i,
  input  wire        [31:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] var_x;
    logic signed [31:0] var_y;
    logic signed [31:0] cov_xy;
    logic               singular;
  } fusion_t;

  localparam longint ARCTAN_Q13 [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16,
                                         8, 4, 2, 1};
  localparam longint U31_TOP = 64'h7FFF_FFFF;

  logic        [30:0] coeff_along, coeff_across;
  logic signed [31:0] est_x, est_y, est_var_x, est_var_y, est_cov_xy;
  fusion_t            fused_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint bearing_q13(longint x, longint y);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 12868;
      end else begin
        x = -y; y = t; z = -12868;
      end
    end
    for (int i = 0; i < 14; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN_Q13[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN_Q13[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic void rotate_q30(input longint z, output longint c, output longint s);
    longint x, y, nx, ny;
    x = 652032875;
    y = 0;
    for (int i = 0; i < 14; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN_Q13[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN_Q13[i];
      end
      x = nx; y = ny;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint gain_q24(longint num, longint det);
    longint g;
    g = (num * 16777216) / det;
    if (g > 268435456) g = 268435456;
    if (g < -268435456) g = -268435456;
    return g;
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic fusion_t fuse_landmark(longint mx, longint my, longint r, longint vx,
                                            longint vy, longint hd);
    fusion_t res;
    longint rr, a, b, alpha, c, s, cc, ss, sc, m00, m01, m11;
    longint p, q, sv, sa, sb, sd, ps, qs, ssc, as_, bs, ds, det, mx_mag;
    longint g00, g01, g10, g11, dx, dy;
    int k;
    p = est_var_x; q = est_cov_xy; sv = est_var_y;
    rr = (r * r) >> 16;
    if (rr > U31_TOP) rr = U31_TOP;
    a = (rr * longint'(coeff_along)) >> 16;
    if (a > U31_TOP) a = U31_TOP;
    b = (r * longint'(coeff_across)) >> 16;
    if (b > U31_TOP) b = U31_TOP;
    alpha = hd + bearing_q13(mx - vx, my - vy);
    while (alpha > 12868) alpha -= 25736;
    while (alpha < -12868) alpha += 25736;
    rotate_q30(alpha, c, s);
    cc = (c * c) >>> 30; ss = (s * s) >>> 30; sc = (s * c) >>> 30;
    m00 = (a * cc + b * ss) >>> 30;
    m11 = (a * ss + b * cc) >>> 30;
    m01 = ((a - b) * sc) >>> 30;
    sa = m00 + p; sb = m01 + q; sd = m11 + sv;
    mx_mag = absl(sa);
    if (absl(sb) > mx_mag) mx_mag = absl(sb);
    if (absl(sd) > mx_mag) mx_mag = absl(sd);
    if (absl(p) > mx_mag) mx_mag = absl(p);
    if (absl(q) > mx_mag) mx_mag = absl(q);
    if (absl(sv) > mx_mag) mx_mag = absl(sv);
    k = 0;
    while ((mx_mag >>> k) > 262144) k++;
    as_ = sa >>> k; bs = sb >>> k; ds = sd >>> k;
    ps = p >>> k; qs = q >>> k; ssc = sv >>> k;
    det = as_ * ds - bs * bs;
    res.singular = (det == 0);
    if (det != 0) begin
      g00 = gain_q24(ps * ds - qs * bs, det);
      g01 = gain_q24(qs * as_ - ps * bs, det);
      g10 = gain_q24(qs * ds - ssc * bs, det);
      g11 = gain_q24(ssc * as_ - qs * bs, det);
      dx = mx - est_x; dy = my - est_y;
      est_x = clip32(longint'(est_x) + ((g00 * dx + g01 * dy) >>> 24));
      est_y = clip32(longint'(est_y) + ((g10 * dx + g11 * dy) >>> 24));
      est_var_x = clip32((g00 * m00 + g01 * m01) >>> 24);
      est_cov_xy = clip32((g00 * m01 + g01 * m11) >>> 24);
      est_var_y = clip32((g10 * m01 + g11 * m11) >>> 24);
    end
    res.pos_x = est_x; res.pos_y = est_y;
    res.var_x = est_var_x; res.var_y = est_var_y; res.cov_xy = est_cov_xy;
    return res;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    fusion_t want;
    if (!rst_ni) begin
      coeff_along = 31'd65536; coeff_across = 31'd65536;
      est_x = 0; est_y = 0; est_var_x = 65536; est_var_y = 65536; est_cov_xy = 0;
      fused_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALONG:  coeff_along = cfg_data_i[30:0];
          CFG_ACROSS: coeff_across = cfg_data_i[30:0];
          CFG_POS_X:  est_x = cfg_data_i;
          CFG_POS_Y:  est_y = cfg_data_i;
          CFG_VAR_X:  est_var_x = {1'b0, cfg_data_i[30:0]};
          CFG_VAR_Y:  est_var_y = {1'b0, cfg_data_i[30:0]};
          CFG_COV_XY: est_cov_xy = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        fused_q.push_back(fuse_landmark(meas_x_i, meas_y_i, range_to_target_i, vehicle_x_i,
                                        vehicle_y_i, vehicle_heading_i));
      if (out_valid_i && !out_stall_i) begin
        if (fused_q.size() == 0) begin
          $error("unexpected result fused_x %0d", fused_x_i);
          fail_count_o++;
        end else begin
          want = fused_q.pop_front();
          check_field("fused_x", want.pos_x, fused_x_i);
          check_field("fused_y", want.pos_y, fused_y_i);
          check_field("fused_var_x", want.var_x, fused_var_x_i);
          check_field("fused_var_y", want.var_y, fused_var_y_i);
          check_field("fused_cov_xy", want.cov_xy, fused_cov_xy_i);
          check_field("singular_flag", want.singular, singular_flag_i);
        end
      end
    end
    pending_o <= fused_q.size();
  end

endmodule

FILE: dv/tb_landmark_position_fusion_2d_core.sv
`timescale 1ns / 1ps
module tb_landmark_position_fusion_2d_core;
  import lpf2d_pkg::*;

  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 3000000;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] meas_x_i, meas_y_i, vehicle_x_i, vehicle_y_i;
  logic        [30:0] range_to_target_i;
  logic signed [15:0] vehicle_heading_i;
  logic signed [31:0] fused_x_o, fused_y_o, fused_var_x_o, fused_var_y_o, fused_cov_xy_o;
  logic               singular_flag_o;
  logic               cfg_we_i;
  logic        [2:0]  cfg_idx_i;
  logic        [31:0] cfg_data_i;
  int                 fail_count, pending, cycles, send_idle_pct, recv_idle_pct;

  landmark_position_fusion_2d_core DUT (.*);

  lpf2d_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .meas_x_i, .meas_y_i,
    .range_to_target_i, .vehicle_x_i, .vehicle_y_i, .vehicle_heading_i,
    .out_valid_i(out_valid_o), .out_stall_i, .fused_x_i(fused_x_o), .fused_y_i(fused_y_o),
    .fused_var_x_i(fused_var_x_o), .fused_var_y_i(fused_var_y_o),
    .fused_cov_xy_i(fused_cov_xy_o), .singular_flag_i(singular_flag_o), .cfg_we_i,
    .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_setup(logic [31:0] along, logic [31:0] across, logic [31:0] px,
                            logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                            logic [31:0] cxy);
    write_reg(CFG_ALONG, along);
    write_reg(CFG_ACROSS, across);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_VAR_X, vx);
    write_reg(CFG_VAR_Y, vy);
    write_reg(CFG_COV_XY, cxy);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(logic [31:0] mx, logic [31:0] my, logic [30:0] r,
                              logic [31:0] vx, logic [31:0] vy, logic [15:0] hd);
    in_valid_i <= 1'b1;
    meas_x_i <= mx;
    meas_y_i <= my;
    range_to_target_i <= r;
    vehicle_x_i <= vx;
    vehicle_y_i <= vy;
    vehicle_heading_i <= hd;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || in_stall_o) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_request;
    logic [31:0] vx, vy, mx, my;
    logic [30:0] r;
    logic [15:0] hd;
    int mode;
    mode = $urandom_range(99);
    vx = $urandom; vy = $urandom; mx = $urandom; my = $urandom;
    r = $urandom; hd = $urandom;
    if (mode < 60) begin
      vx = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
      vy = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
      mx = vx + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
      my = vy + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
      r = $urandom_range(0, 2 ** 22);
      hd = $signed($urandom_range(0, 51472)) - 25736;
    end else if (mode < 80) begin
      r = $urandom_range(0, 2 ** 25);
    end
    send_request(mx, my, r, vx, vy, hd);
  endtask

  task automatic random_setup(bit wide);
    load_setup(wide ? $urandom : $urandom_range(0, 2 ** 18),
               wide ? $urandom : $urandom_range(0, 2 ** 18),
               $urandom_range(0, 2 ** 24) - 2 ** 23, $urandom_range(0, 2 ** 24) - 2 ** 23,
               wide ? $urandom : $urandom_range(0, 2 ** 22),
               wide ? $urandom : $urandom_range(0, 2 ** 22),
               $signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
  endtask

  initial begin
    rst_ni = 1'b0;
    cycles = 0;
    in_valid_i = 1'b0;
    meas_x_i = '0; meas_y_i = '0; range_to_target_i = '0;
    vehicle_x_i = '0; vehicle_y_i = '0; vehicle_heading_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_ALONG; cfg_data_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 76;
    send_request('0, '0, '0, '0, '0, '0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 16'sd25736);
    send_request(32'h8000_0000, 32'h8000_0000, 31'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 -16'sd25736);
    send_request(32'h0001_0000, 32'h0002_0000, 31'd1, '0, '0, 16'h7FFF);
    send_request(-32'sh0003_0000, '0, 31'd200000, '0, '0, 16'h8000);
    send_request(-32'sh0003_0000, -32'sh0001_0000, 31'd300000, '0, '0, 16'sd12868);
    send_request('0, 32'h0005_0000, 31'd500000, '0, '0, -16'sd12868);
    send_request(32'h0005_0000, '0, 31'd65536, '0, '0, 16'sd100);
    drain();

    load_setup('0, '0, 32'h0010_0000, 32'hFFF0_0000, '0, '0, '0);
    send_request(32'h0001_0000, 32'h0001_0000, '0, '0, '0, '0);
    send_request(32'h0002_0000, 32'h0003_0000, '0, '0, '0, 16'sd5000);
    drain();

    load_setup(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'h8000_0000);
    write_reg(CFG_NONE, 32'hDEAD_BEEF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0, 16'sd3000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 31'd1000000, '0, '0, -16'sd3000);
    send_request('0, '0, 31'h7FFF_FFFF, '0, '0, '0);
    drain();

    load_setup(32'd65536, 32'd65536, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h0100_0000, 32'h0100_0000, 31'd65536, '0, '0, '0);
    send_request(32'h0100_0000, 32'hFF00_0000, 31'd65536, '0, '0, 16'sd20000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 25 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_setup(blk == 3);
        for (int n = 0; n < 42; n++) random_request();
        drain();
      end
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
